// ===== rtl/lc3b_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3b_pkg
// Shared types and constants for the LC-3b executor: state codes, opcodes,
// item modes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lc3b_pkg;

  localparam int          MEM_WORDS_DEF = 32768;
  localparam int          NUM_REGS      = 8;
  localparam logic [15:0] START_PC_RST  = 16'h3000;
  localparam logic [2:0]  CC_RST        = 3'b010;

  localparam int IN_W  = 40;
  localparam int OUT_W = 64;

  // item modes
  localparam logic [2:0] MODE_EXEC    = 3'd0;
  localparam logic [2:0] MODE_WRITE   = 3'd1;
  localparam logic [2:0] MODE_READ    = 3'd2;
  localparam logic [2:0] MODE_RESTART = 3'd3;
  localparam logic [2:0] MODE_REG     = 3'd4;

  // opcodes
  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LDB  = 4'h2;
  localparam logic [3:0] OP_STB  = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDW  = 4'h6;
  localparam logic [3:0] OP_STW  = 4'h7;
  localparam logic [3:0] OP_XOR  = 4'h9;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_SHF  = 4'hD;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [1:0] SHF_LEFT  = 2'd0;
  localparam logic [1:0] SHF_RLOG  = 2'd1;
  localparam logic [1:0] SHF_NONE  = 2'd2;
  localparam logic [1:0] SHF_RARI  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear;   // write zero at the sweep counter
    logic load;    // capture the input word
    logic fetch;   // read memory at the PC
    logic decode;  // latch instruction, read operand memory word
    logic exec;    // execute phase, memory address held
    logic commit;  // update state and result register
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } sts_t;

  function automatic logic [2:0] codes(input logic [15:0] v);
    if (v == 16'h0000) begin
      return 3'b010;
    end else if (v[15]) begin
      return 3'b100;
    end
    return 3'b001;
  endfunction

endpackage

// ===== rtl/lc3b_ctrl.sv =====
// ----------------------------------------------------------------------------
// lc3b_ctrl
// Sequencer: memory clear sweep, then fetch / decode / execute per word, and
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module lc3b_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lc3b_pkg::sts_t sts,
  output lc3b_pkg::cmd_t cmd
);

  lc3b_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lc3b_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lc3b_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = lc3b_pkg::ST_IDLE;
        end
      end
      lc3b_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lc3b_pkg::ST_FETCH;
        end
      end
      lc3b_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = lc3b_pkg::ST_DECODE;
      end
      lc3b_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = lc3b_pkg::ST_EXEC;
      end
      lc3b_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = lc3b_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lc3b_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/lc3b_dpath.sv =====
// ----------------------------------------------------------------------------
// lc3b_dpath
// Datapath: main memory, register file, PC, condition codes, ALU/shifter,
// address adder and the result register.
// ----------------------------------------------------------------------------
module lc3b_dpath #(
  parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [15:0]                cfg_wdata,
  input  logic [lc3b_pkg::IN_W-1:0]  in_data,
  output logic [lc3b_pkg::OUT_W-1:0] out_data,
  input  lc3b_pkg::cmd_t             cmd,
  output lc3b_pkg::sts_t             sts
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0]   mem [MEM_WORDS];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [15:0]   mem_wd;
  logic [15:0]   mem_rd;
  logic [AW-1:0] clr_cnt;

  logic [15:0] rf [lc3b_pkg::NUM_REGS];
  logic [2:0]  rd_idx;
  logic [15:0] rf_rd;

  logic [15:0] start_pc, pc;
  logic [2:0]  cc;
  logic [2:0]  item_mode;
  logic [15:0] item_addr, item_wdata;
  logic [15:0] ir, a_val, ea, ea_c;

  // execute-phase values
  logic        run;
  logic [3:0]  op;
  logic [15:0] npc, res, b_val, pc_nx, mw_data;
  logic [2:0]  dr, cc_nx;
  logic        wr, ccw, mw;
  logic [7:0]  ld_byte;

  // result register
  logic [15:0] o_pc, o_rval, o_rdata;
  logic [2:0]  o_cc, o_ridx;
  logic        o_rw, o_mw, o_halt;

  assign sts.clear_done = (clr_cnt == AW'(MEM_WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // ---------------- register file read port ----------------
  assign op = ir[15:12];

  always_comb begin
    if (cmd.decode) begin
      rd_idx = mem_rd[8:6];
    end else if (item_mode == lc3b_pkg::MODE_REG) begin
      rd_idx = item_addr[2:0];
    end else if (op == lc3b_pkg::OP_ADD || op == lc3b_pkg::OP_AND ||
                 op == lc3b_pkg::OP_XOR) begin
      rd_idx = ir[2:0];
    end else begin
      rd_idx = ir[11:9];
    end
  end

  assign rf_rd = rf[rd_idx];

  // ---------------- effective address (decode phase) ----------------
  always_comb begin
    case (mem_rd[15:12])
      lc3b_pkg::OP_LDB, lc3b_pkg::OP_STB:
        ea_c = rf_rd + {{10{mem_rd[5]}}, mem_rd[5:0]};
      lc3b_pkg::OP_LDW, lc3b_pkg::OP_STW:
        ea_c = rf_rd + {{9{mem_rd[5]}}, mem_rd[5:0], 1'b0};
      lc3b_pkg::OP_TRAP:
        ea_c = {7'd0, mem_rd[7:0], 1'b0};
      default:
        ea_c = 16'h0000;
    endcase
  end

  // ---------------- execute ----------------
  assign run     = (item_mode == lc3b_pkg::MODE_EXEC) && (pc != 16'h0000);
  assign ld_byte = ea[0] ? mem_rd[15:8] : mem_rd[7:0];
  assign b_val   = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf_rd;

  always_comb begin
    npc     = pc + 16'd2;
    res     = 16'h0000;
    dr      = ir[11:9];
    wr      = 1'b0;
    ccw     = 1'b0;
    mw      = 1'b0;
    mw_data = rf_rd;
    case (op)
      lc3b_pkg::OP_ADD: begin
        res = a_val + b_val; wr = 1'b1; ccw = 1'b1;
      end
      lc3b_pkg::OP_AND: begin
        res = a_val & b_val; wr = 1'b1; ccw = 1'b1;
      end
      lc3b_pkg::OP_XOR: begin
        res = a_val ^ b_val; wr = 1'b1; ccw = 1'b1;
      end
      lc3b_pkg::OP_BR: begin
        if ((ir[11:9] & cc) != 3'b000) begin
          npc = pc + 16'd2 + {{6{ir[8]}}, ir[8:0], 1'b0};
        end
      end
      lc3b_pkg::OP_JMP: begin
        npc = a_val;
      end
      lc3b_pkg::OP_JSR: begin
        res = pc + 16'd2; dr = 3'd7; wr = 1'b1;
        if (ir[11]) begin
          npc = pc + 16'd2 + {{4{ir[10]}}, ir[10:0], 1'b0};
        end else begin
          npc = a_val;
        end
      end
      lc3b_pkg::OP_LDB: begin
        res = {{8{ld_byte[7]}}, ld_byte}; wr = 1'b1; ccw = 1'b1;
      end
      lc3b_pkg::OP_LDW: begin
        res = mem_rd; wr = 1'b1; ccw = 1'b1;
      end
      lc3b_pkg::OP_LEA: begin
        res = pc + 16'd2 + {{6{ir[8]}}, ir[8:0], 1'b0}; wr = 1'b1;
      end
      lc3b_pkg::OP_SHF: begin
        ccw = 1'b1;
        case (ir[5:4])
          lc3b_pkg::SHF_LEFT: begin
            res = a_val << ir[3:0]; wr = 1'b1;
          end
          lc3b_pkg::SHF_RLOG: begin
            res = a_val >> ir[3:0]; wr = 1'b1;
          end
          lc3b_pkg::SHF_RARI: begin
            res = 16'($signed(a_val) >>> ir[3:0]); wr = 1'b1;
          end
          default: begin
            res = rf_rd;
          end
        endcase
      end
      lc3b_pkg::OP_STB: begin
        mw      = 1'b1;
        mw_data = ea[0] ? {rf_rd[7:0], mem_rd[7:0]} : {mem_rd[15:8], rf_rd[7:0]};
      end
      lc3b_pkg::OP_STW: begin
        mw = 1'b1;
      end
      lc3b_pkg::OP_TRAP: begin
        res = pc + 16'd2; dr = 3'd7; wr = 1'b1; npc = mem_rd;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pc_nx = pc;
    cc_nx = cc;
    if (run) begin
      pc_nx = npc;
      if (ccw) begin
        cc_nx = lc3b_pkg::codes(res);
      end
    end else if (item_mode == lc3b_pkg::MODE_RESTART) begin
      pc_nx = start_pc;
    end
  end

  // ---------------- memory port ----------------
  always_comb begin
    mem_we = 1'b0;
    mem_wd = '0;
    if (cmd.clear) begin
      mem_addr = clr_cnt;
      mem_we   = 1'b1;
    end else if (cmd.fetch) begin
      mem_addr = pc[AW:1];
    end else if (cmd.decode) begin
      mem_addr = (item_mode == lc3b_pkg::MODE_EXEC) ? ea_c[AW:1] : item_addr[AW:1];
    end else if (cmd.exec) begin
      // same address as decode, so the read word holds while stalled
      mem_addr = (item_mode == lc3b_pkg::MODE_EXEC) ? ea[AW:1] : item_addr[AW:1];
      if (cmd.commit && run && mw) begin
        mem_we = 1'b1;
        mem_wd = mw_data;
      end else if (cmd.commit && item_mode == lc3b_pkg::MODE_WRITE) begin
        mem_we = 1'b1;
        mem_wd = item_wdata;
      end
    end else begin
      mem_addr = pc[AW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end else begin
      mem_rd <= mem[mem_addr];
    end
  end

  // ---------------- architectural state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= lc3b_pkg::START_PC_RST;
      pc       <= '0;
      cc       <= lc3b_pkg::CC_RST;
      for (int i = 0; i < lc3b_pkg::NUM_REGS; i++) begin
        rf[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        start_pc <= cfg_wdata;
      end
      if (cmd.commit) begin
        pc <= pc_nx;
        cc <= cc_nx;
        if (run && wr) begin
          rf[dr] <= res;
        end
      end
    end
  end

  // ---------------- item and instruction latches ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode  <= in_data[2:0];
      item_addr  <= in_data[18:3];
      item_wdata <= in_data[34:19];
    end
    if (cmd.decode) begin
      ir    <= mem_rd;
      a_val <= rf_rd;
      ea    <= ea_c;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_pc    <= pc_nx;
      o_cc    <= cc_nx;
      o_halt  <= (pc_nx == 16'h0000);
      o_rw    <= run && wr;
      o_mw    <= (run && mw) || (item_mode == lc3b_pkg::MODE_WRITE);
      o_rdata <= (item_mode == lc3b_pkg::MODE_READ) ? mem_rd : 16'h0000;
      if (run && wr) begin
        o_ridx <= dr;
        o_rval <= res;
      end else if (item_mode == lc3b_pkg::MODE_REG) begin
        o_ridx <= item_addr[2:0];
        o_rval <= rf_rd;
      end else begin
        o_ridx <= 3'd0;
        o_rval <= 16'h0000;
      end
    end
  end

  assign out_data = {7'd0, o_halt, o_rdata, o_mw, o_rval, o_ridx, o_rw,
                     o_cc[0], o_cc[1], o_cc[2], o_pc};

endmodule

// ===== rtl/lc3b_instruction_executor.sv =====
// An accepted input word passes through fetch, decode and execute to the
// result word; a new word is taken only in the idle state, after the last one
// commits, as the main memory has a single port (fetch, one data read, then
// the write). Execute holds while the result register is still full.
// Reset: registers and PC clear, codes to Z, start_pc to 0x3000; the memory
// is then swept to zero, word by word, during which no word is taken.
// ----------------------------------------------------------------------------
// lc3b_instruction_executor
// LC-3b core: one stream word runs one instruction, one memory/register
// access or a restart of the PC, and returns one status word.
// ----------------------------------------------------------------------------
module lc3b_instruction_executor #(
  parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0], address[18:3], write_data[34:19], zero[39:35]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pc_now[15:0], cond_n[16], cond_z[17], cond_p[18], reg_written[19],
  // reg_index[22:20], reg_value[38:23], mem_written[39], read_data[55:40],
  // halted[56], zero[63:57]
  output logic [63:0] m_axis_tdata
);

  lc3b_pkg::cmd_t cmd;
  lc3b_pkg::sts_t sts;

  lc3b_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lc3b_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
